// ===== rtl/ultrasonic_echo_range_meter_unit_defines.svh =====
// Assertion macros used by the range meter port checker.
`ifndef ULTRASONIC_ECHO_RANGE_METER_UNIT_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGE_METER_UNIT_DEFINES_SVH

// Clocked implication check, masked while reset is asserted.
`define UERM_ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define UERM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/uerm_pkg.sv =====
// Types, constants and helper functions of the ultrasonic echo range meter.
`default_nettype none

package uerm_pkg;

    localparam int DIST_W = 14;
    localparam int COUNT_W = 16;
    localparam int MAX_DIGIT = 11;

    localparam logic [15:0] RANGE_LIMIT_RESET = 16'd4000;

    // floor(count * 10 / 58) == floor(count * 5 * ceil(2^24 / 29) / 2^24) for 16-bit counts
    localparam int DIST_SHIFT = 24;
    localparam logic [21:0] DIST_MULT = 22'd2892625;

    localparam logic [7:0] SEG_DASH = 8'h40;
    localparam logic [7:0] SEG_DP = 8'h80;
    localparam logic [5:0] ASCII_ZERO = 6'd48;

    typedef logic [DIST_W-1:0] dist_t;

    localparam dist_t WEIGHT_THOUSANDS = 14'd1000;
    localparam dist_t WEIGHT_HUNDREDS = 14'd100;
    localparam dist_t WEIGHT_TENS = 14'd10;

    typedef struct packed {
        logic [3:0] digit;
        dist_t      rest;
    } digit_split_t;

    typedef struct packed {
        logic               done;
        logic [COUNT_W-1:0] count;
        logic               ovf;
    } pulse_meas_t;

    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        case (digit)
            4'd0: code = 8'h3f;
            4'd1: code = 8'h06;
            4'd2: code = 8'h5b;
            4'd3: code = 8'h4f;
            4'd4: code = 8'h66;
            4'd5: code = 8'h6d;
            4'd6: code = 8'h7d;
            4'd7: code = 8'h07;
            4'd8: code = 8'h7f;
            4'd9: code = 8'h6f;
            4'd10: code = 8'h77;
            4'd11: code = 8'h7c;
            4'd12: code = 8'h39;
            4'd13: code = 8'h5e;
            4'd14: code = 8'h79;
            default: code = 8'h71;
        endcase
        return code;
    endfunction

    // Pick the leading digit by parallel compares against its multiples.
    function automatic digit_split_t split_digit(input dist_t value, input dist_t weight);
        digit_split_t res;
        dist_t        step;
        res.digit = 4'd0;
        res.rest = value;
        for (int k = 1; k <= MAX_DIGIT; k++) begin
            step = dist_t'(k) * weight;
            if (value >= step) begin
                res.digit = 4'(k);
                res.rest = value - step;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/uerm_pulse_timer.sv =====
// Echo edge detector and pulse width counter with overflow flag.
`default_nettype none

module uerm_pulse_timer (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 accept,
    input  wire logic                 echo_level,
    output uerm_pkg::pulse_meas_t     meas
);
    import uerm_pkg::*;

    logic               echo_before_reg, echo_before_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               ovf_reg, ovf_next;

    always_comb begin
        echo_before_next = echo_before_reg;
        count_next = count_reg;
        ovf_next = ovf_reg;
        if (accept) begin
            echo_before_next = echo_level;
            if (echo_level) begin
                count_next = count_reg + 1'b1;
                if (&count_reg) begin
                    ovf_next = 1'b1;
                end
            end else if (echo_before_reg) begin
                count_next = '0;
                ovf_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            echo_before_reg <= 1'b0;
            count_reg <= '0;
            ovf_reg <= 1'b0;
        end else begin
            echo_before_reg <= echo_before_next;
            count_reg <= count_next;
            ovf_reg <= ovf_next;
        end
    end

    assign meas.done = accept && !echo_level && echo_before_reg;
    assign meas.count = count_reg;
    assign meas.ovf = ovf_reg;

endmodule

`default_nettype wire

// ===== rtl/ultrasonic_echo_range_meter_unit.sv =====
// Top level of the ultrasonic echo range meter.
// Usage:
//   Input channel (s_valid/s_ready, s_echo_level): one word per timer tick
//   carrying the sampled echo level. Words are taken every cycle while
//   s_ready is high. While the echo is high a 16-bit pulse counter advances;
//   a wrap past 65535 marks the pulse as overflowed.
//   Result channel (m_valid/m_ready, m_*): one word per falling echo edge,
//   holding distance in mm, four seven-segment codes, four ASCII digits and
//   the out-of-range flag. Words without a falling edge give no result.
//   Configuration: cfg_wr_en/cfg_wr_data load the 16-bit range limit
//   (reset 4000); write it only while the block is idle.
//   Path: the edge word passes the five-stage pipeline (capture, distance
//   multiply, thousands, hundreds, tens/output) before its result is on
//   m_valid. Throughput: one input word per cycle while s_ready is high.
//   Stall: when m_ready is low the result holds; stages behind it fill their
//   empty slots, and s_ready drops only once every stage holds a result.
//   Reset (aresetn low, synchronous): clears the counter, overflow flag,
//   echo history, pipeline valids and restores the range limit.
`default_nettype none

module ultrasonic_echo_range_meter_unit (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output wire logic                    s_ready,
    input  wire logic                    s_echo_level,
    output wire logic                    m_valid,
    input  wire logic                    m_ready,
    output wire logic [13:0]             m_distance_mm,
    output wire logic [7:0]              m_seg_thousands,
    output wire logic [7:0]              m_seg_hundreds,
    output wire logic [7:0]              m_seg_tens,
    output wire logic [7:0]              m_seg_ones,
    output wire logic [5:0]              m_char_thousands,
    output wire logic [5:0]              m_char_hundreds,
    output wire logic [5:0]              m_char_tens,
    output wire logic [5:0]              m_char_ones,
    output wire logic                    m_out_of_range,
    input  wire logic                    cfg_wr_en,
    input  wire logic [15:0]             cfg_wr_data
);
    import uerm_pkg::*;

    // range limit register
    logic [15:0] limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= RANGE_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    // stage valids and load enables; each stage fills when empty or moving
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_v_reg;
    logic load1, load2, load3, load4, load_out;
    logic s_accept;

    assign load_out = !out_v_reg || m_ready;
    assign load4 = !v4_reg || load_out;
    assign load3 = !v3_reg || load4;
    assign load2 = !v2_reg || load3;
    assign load1 = !v1_reg || load2;
    assign s_ready = load1;
    assign s_accept = s_valid && load1;

    // pulse timer front end: counts echo width, flags falling edge
    pulse_meas_t meas;

    uerm_pulse_timer u_timer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (s_accept),
        .echo_level (s_echo_level),
        .meas       (meas)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (load1) v1_reg <= meas.done;
            if (load2) v2_reg <= v1_reg;
            if (load3) v3_reg <= v2_reg;
            if (load4) v4_reg <= v3_reg;
            if (load_out) out_v_reg <= v4_reg;
        end
    end

    // stage 1: capture the finished pulse
    logic [COUNT_W-1:0] s1_count_reg;
    logic               s1_ovf_reg;

    always_ff @(posedge aclk) begin
        if (load1) begin
            s1_count_reg <= meas.count;
            s1_ovf_reg <= meas.ovf;
        end
    end

    // stage 2: distance by reciprocal multiply
    logic [COUNT_W+21:0] dist_prod;
    dist_t               s2_dist_reg;
    logic                s2_ovf_reg;

    assign dist_prod = (COUNT_W+22)'(s1_count_reg) * (COUNT_W+22)'(DIST_MULT);

    always_ff @(posedge aclk) begin
        if (load2) begin
            s2_dist_reg <= dist_prod[DIST_SHIFT +: DIST_W];
            s2_ovf_reg <= s1_ovf_reg;
        end
    end

    // stage 3: thousands digit and range check
    digit_split_t split3;
    dist_t        s3_dist_reg;
    logic [3:0]   s3_d3_reg;
    logic [9:0]   s3_rest_reg;
    logic         s3_oor_reg;

    assign split3 = split_digit(s2_dist_reg, WEIGHT_THOUSANDS);

    always_ff @(posedge aclk) begin
        if (load3) begin
            s3_dist_reg <= s2_dist_reg;
            s3_d3_reg <= split3.digit;
            s3_rest_reg <= split3.rest[9:0];
            s3_oor_reg <= ({2'b00, s2_dist_reg} >= limit_reg) || s2_ovf_reg;
        end
    end

    // stage 4: hundreds digit
    digit_split_t split2;
    dist_t        s4_dist_reg;
    logic [3:0]   s4_d3_reg;
    logic [3:0]   s4_d2_reg;
    logic [6:0]   s4_rest_reg;
    logic         s4_oor_reg;

    assign split2 = split_digit({4'd0, s3_rest_reg}, WEIGHT_HUNDREDS);

    always_ff @(posedge aclk) begin
        if (load4) begin
            s4_dist_reg <= s3_dist_reg;
            s4_d3_reg <= s3_d3_reg;
            s4_d2_reg <= split2.digit;
            s4_rest_reg <= split2.rest[6:0];
            s4_oor_reg <= s3_oor_reg;
        end
    end

    // stage 5: tens and ones digits, glyphs and characters into the output word
    digit_split_t split1;
    logic [3:0]   d0;
    logic [13:0]  dist_reg;
    logic [7:0]   seg3_reg, seg2_reg, seg1_reg, seg0_reg;
    logic [5:0]   chr3_reg, chr2_reg, chr1_reg, chr0_reg;
    logic         oor_reg;

    assign split1 = split_digit({7'd0, s4_rest_reg}, WEIGHT_TENS);
    assign d0 = split1.rest[3:0];

    always_ff @(posedge aclk) begin
        if (load_out) begin
            dist_reg <= s4_dist_reg;
            oor_reg <= s4_oor_reg;
            // dashes replace glyphs only; characters keep the digits
            seg3_reg <= s4_oor_reg ? SEG_DASH : (seg_code(s4_d3_reg) | SEG_DP);
            seg2_reg <= s4_oor_reg ? SEG_DASH : seg_code(s4_d2_reg);
            seg1_reg <= s4_oor_reg ? SEG_DASH : seg_code(split1.digit);
            seg0_reg <= s4_oor_reg ? SEG_DASH : seg_code(d0);
            chr3_reg <= ASCII_ZERO + {2'b00, s4_d3_reg};
            chr2_reg <= ASCII_ZERO + {2'b00, s4_d2_reg};
            chr1_reg <= ASCII_ZERO + {2'b00, split1.digit};
            chr0_reg <= ASCII_ZERO + {2'b00, d0};
        end
    end

    assign m_valid = out_v_reg;
    assign m_distance_mm = dist_reg;
    assign m_seg_thousands = seg3_reg;
    assign m_seg_hundreds = seg2_reg;
    assign m_seg_tens = seg1_reg;
    assign m_seg_ones = seg0_reg;
    assign m_char_thousands = chr3_reg;
    assign m_char_hundreds = chr2_reg;
    assign m_char_tens = chr1_reg;
    assign m_char_ones = chr0_reg;
    assign m_out_of_range = oor_reg;

endmodule

`default_nettype wire

// ===== rtl/uerm_checker.sv =====
// Port-level checker for the range meter and its bind.
`default_nettype none
`include "ultrasonic_echo_range_meter_unit_defines.svh"

module uerm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [13:0] m_distance_mm,
    input wire logic [7:0]  m_seg_thousands,
    input wire logic [7:0]  m_seg_hundreds,
    input wire logic [7:0]  m_seg_tens,
    input wire logic [7:0]  m_seg_ones,
    input wire logic [5:0]  m_char_thousands,
    input wire logic [5:0]  m_char_hundreds,
    input wire logic [5:0]  m_char_tens,
    input wire logic [5:0]  m_char_ones,
    input wire logic        m_out_of_range
);
    import uerm_pkg::*;

    logic        m_stall;
    logic [70:0] m_word;
    logic        all_dash;
    logic        glyph_ok;
    logic        span_ok;

    function automatic logic is_digit_char(input logic [5:0] chr);
        return (chr >= ASCII_ZERO) && (chr <= ASCII_ZERO + 6'd9);
    endfunction

    assign m_stall = m_valid && !m_ready;
    assign m_word = {m_distance_mm, m_seg_thousands, m_seg_hundreds, m_seg_tens, m_seg_ones,
                     m_char_thousands, m_char_hundreds, m_char_tens, m_char_ones,
                     m_out_of_range};
    assign all_dash = (m_seg_thousands == SEG_DASH) && (m_seg_hundreds == SEG_DASH)
                      && (m_seg_tens == SEG_DASH) && (m_seg_ones == SEG_DASH);
    assign glyph_ok = m_seg_thousands[7] && (m_seg_hundreds != SEG_DASH);
    assign span_ok = (m_distance_mm <= 14'd11299) && is_digit_char(m_char_hundreds)
                     && is_digit_char(m_char_tens) && is_digit_char(m_char_ones)
                     && (m_char_thousands >= ASCII_ZERO)
                     && (m_char_thousands <= ASCII_ZERO + 6'd11);

    // stalled result word holds
    `UERM_ASSERT_RST(a_hold, aclk, aresetn, m_stall |=> m_valid && $stable(m_word), "hold broken")

    // dashes on every digit when out of range
    `UERM_ASSERT_RST(a_dash, aclk, aresetn, m_valid && m_out_of_range |-> all_dash, "no dashes")

    // in range the thousands glyph carries the decimal point
    `UERM_ASSERT_RST(a_point, aclk, aresetn, m_valid && !m_out_of_range |-> glyph_ok, "bad glyph")

    // digits and distance stay within their spans
    `UERM_ASSERT_ALWAYS(a_span, aclk, !aresetn || !m_valid || span_ok, "digit out of span")

endmodule

bind ultrasonic_echo_range_meter_unit uerm_checker u_checker (.*);

`default_nettype wire

// ===== sim/ultrasonic_echo_range_meter_unit_checker.sv =====
// Checker for the range meter: predicts each echo reading and compares result words.
module ultrasonic_echo_range_meter_unit_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_echo_level,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [13:0] m_distance_mm,
    input  logic [7:0]  m_seg_thousands,
    input  logic [7:0]  m_seg_hundreds,
    input  logic [7:0]  m_seg_tens,
    input  logic [7:0]  m_seg_ones,
    input  logic [5:0]  m_char_thousands,
    input  logic [5:0]  m_char_hundreds,
    input  logic [5:0]  m_char_tens,
    input  logic [5:0]  m_char_ones,
    input  logic        m_out_of_range,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    output int          mismatch_count,
    output int          readings_pending,
    output int          readings_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import uerm_pkg::*;

    // Segment glyphs 0..F, digit 0 in the low byte.
    localparam logic [16*8-1:0] GLYPHS = {
        8'h71, 8'h79, 8'h5e, 8'h39, 8'h7c, 8'h77, 8'h6f, 8'h7f,
        8'h07, 8'h7d, 8'h6d, 8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f
    };

    typedef struct packed {
        logic [13:0] distance;
        logic [7:0]  seg_th;
        logic [7:0]  seg_hu;
        logic [7:0]  seg_te;
        logic [7:0]  seg_on;
        logic [5:0]  chr_th;
        logic [5:0]  chr_hu;
        logic [5:0]  chr_te;
        logic [5:0]  chr_on;
        logic        oor;
    } range_reading_t;

    range_reading_t pending_q[$];
    logic [15:0]    limit_mm;
    logic [15:0]    tick_count;
    logic           count_wrapped;
    logic           echo_prev;

    function automatic range_reading_t predict_reading(input logic [15:0] count,
                                                       input logic wrapped,
                                                       input logic [15:0] limit);
        range_reading_t rd;
        int             dist_val;
        int             d3;
        int             d2;
        int             d1;
        int             d0;
        logic           oor;
        dist_val = (int'(count) * 10) / 58;
        d3 = (dist_val / 1000) % 16;
        d2 = (dist_val % 1000) / 100;
        d1 = (dist_val % 100) / 10;
        d0 = dist_val % 10;
        oor = (dist_val >= int'(limit)) || wrapped;
        rd.distance = 14'(dist_val);
        if (oor) begin
            rd.seg_th = SEG_DASH;
            rd.seg_hu = SEG_DASH;
            rd.seg_te = SEG_DASH;
            rd.seg_on = SEG_DASH;
        end else begin
            rd.seg_th = GLYPHS[d3*8 +: 8] | SEG_DP;
            rd.seg_hu = GLYPHS[d2*8 +: 8];
            rd.seg_te = GLYPHS[d1*8 +: 8];
            rd.seg_on = GLYPHS[d0*8 +: 8];
        end
        rd.chr_th = ASCII_ZERO + 6'(d3);
        rd.chr_hu = ASCII_ZERO + 6'(d2);
        rd.chr_te = ASCII_ZERO + 6'(d1);
        rd.chr_on = ASCII_ZERO + 6'(d0);
        rd.oor = oor;
        return rd;
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        range_reading_t want;
        if (!aresetn) begin
            pending_q.delete();
            limit_mm = RANGE_LIMIT_RESET;
            tick_count = '0;
            count_wrapped = 1'b0;
            echo_prev = 1'b0;
        end else begin
            // Compare first: a result word never belongs to this edge's input word.
            if (m_valid && m_ready) begin
                if (pending_q.size() == 0) begin
                    $error("result word with no reading pending");
                    mismatch_count++;
                end else begin
                    want = pending_q.pop_front();
                    compare_field("distance_mm", want.distance, m_distance_mm);
                    compare_field("seg_thousands", want.seg_th, m_seg_thousands);
                    compare_field("seg_hundreds", want.seg_hu, m_seg_hundreds);
                    compare_field("seg_tens", want.seg_te, m_seg_tens);
                    compare_field("seg_ones", want.seg_on, m_seg_ones);
                    compare_field("char_thousands", want.chr_th, m_char_thousands);
                    compare_field("char_hundreds", want.chr_hu, m_char_hundreds);
                    compare_field("char_tens", want.chr_te, m_char_tens);
                    compare_field("char_ones", want.chr_on, m_char_ones);
                    compare_field("out_of_range", want.oor, m_out_of_range);
                    readings_seen++;
                end
            end
            if (cfg_wr_en) begin
                limit_mm = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                if (s_echo_level) begin
                    tick_count = tick_count + 16'd1;
                    if (tick_count == 16'd0) begin
                        count_wrapped = 1'b1;
                    end
                end else if (echo_prev) begin
                    pending_q.push_back(predict_reading(tick_count, count_wrapped, limit_mm));
                    tick_count = '0;
                    count_wrapped = 1'b0;
                end
                echo_prev = s_echo_level;
            end
        end
        readings_pending = pending_q.size();
    end

endmodule

// ===== sim/ultrasonic_echo_range_meter_unit_tb.sv =====
// Testbench top for the range meter: echo stimulus, result sink and verdict.
module ultrasonic_echo_range_meter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Hold-off length of the result sink when the block is to be filled up.
    localparam int HOLD_CYCLES = 300;
    // Cycles to let the pipeline settle after the last result word.
    localparam int SETTLE_CYCLES = 10;
    // Echo words per random phase; the last phase also runs until enough readings.
    localparam int PHASE_WORDS = 120;
    localparam int MIN_RANDOM_READINGS = 10;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_echo_level;
    logic        m_valid;
    logic        m_ready;
    logic [13:0] m_distance_mm;
    logic [7:0]  m_seg_thousands;
    logic [7:0]  m_seg_hundreds;
    logic [7:0]  m_seg_tens;
    logic [7:0]  m_seg_ones;
    logic [5:0]  m_char_thousands;
    logic [5:0]  m_char_hundreds;
    logic [5:0]  m_char_tens;
    logic [5:0]  m_char_ones;
    logic        m_out_of_range;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    int          mismatch_count;
    int          readings_pending;
    int          readings_seen;

    // Sender gap switch, and the hold-off handshake with the result sink.
    bit          sender_gaps_on;
    int          hold_requests;
    int          holds_done;
    bit          holding;

    ultrasonic_echo_range_meter_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_echo_level     (s_echo_level),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_distance_mm    (m_distance_mm),
        .m_seg_thousands  (m_seg_thousands),
        .m_seg_hundreds   (m_seg_hundreds),
        .m_seg_tens       (m_seg_tens),
        .m_seg_ones       (m_seg_ones),
        .m_char_thousands (m_char_thousands),
        .m_char_hundreds  (m_char_hundreds),
        .m_char_tens      (m_char_tens),
        .m_char_ones      (m_char_ones),
        .m_out_of_range   (m_out_of_range),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data)
    );

    ultrasonic_echo_range_meter_unit_checker range_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_echo_level     (s_echo_level),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_distance_mm    (m_distance_mm),
        .m_seg_thousands  (m_seg_thousands),
        .m_seg_hundreds   (m_seg_hundreds),
        .m_seg_tens       (m_seg_tens),
        .m_seg_ones       (m_seg_ones),
        .m_char_thousands (m_char_thousands),
        .m_char_hundreds  (m_char_hundreds),
        .m_char_tens      (m_char_tens),
        .m_char_ones      (m_char_ones),
        .m_out_of_range   (m_out_of_range),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .mismatch_count   (mismatch_count),
        .readings_pending (readings_pending),
        .readings_seen    (readings_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #(30_000_000);
        $display("ultrasonic_echo_range_meter_unit_tb NOT OK");
        $finish;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(13, 40);
    endfunction

    // Result sink: random stalls, quiet stretches, and the long hold-off on request.
    initial begin : result_sink
        int idle;
        m_ready = 1'b0;
        holding = 1'b0;
        holds_done = 0;
        @(negedge aclk);
        forever begin
            if (hold_requests != holds_done) begin
                // Hold off long enough for every pipeline stage to fill.
                m_ready <= 1'b0;
                holding = 1'b1;
                repeat (HOLD_CYCLES) @(negedge aclk);
                holding = 1'b0;
                holds_done++;
            end else if ($urandom_range(0, 15) == 0) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(20, 80)) @(negedge aclk);
            end else begin
                idle = idle_length();
                if (idle != 0) begin
                    m_ready <= 1'b0;
                    repeat (idle) @(negedge aclk);
                end
                m_ready <= 1'b1;
                @(negedge aclk);
            end
        end
    end

    // Offer one echo word and hold it until taken. Starts and ends at a falling edge.
    task automatic send_echo(input logic level);
        int idle;
        idle = sender_gaps_on ? idle_length() : 0;
        if (idle != 0) begin
            s_valid <= 1'b0;
            repeat (idle) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_echo_level <= level;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // One echo pulse: high for high_ticks words, then low for low_ticks words.
    task automatic send_pulse(input int high_ticks, input int low_ticks);
        repeat (high_ticks) send_echo(1'b1);
        repeat (low_ticks) send_echo(1'b0);
    endtask

    // Drop valid and wait until every reading is back and the pipeline is quiet.
    task automatic drain_readings();
        s_valid <= 1'b0;
        while (readings_pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Load the range limit; only called with the block drained.
    task automatic write_limit(input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // One random burst: mostly well-formed pulses, some line noise.
    task automatic send_random_burst(inout int sent);
        int r;
        int hi;
        int lo;
        int n;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            n = $urandom_range(1, 12);
            repeat (n) send_echo($urandom_range(0, 1) != 0);
            sent += n;
        end else begin
            if (r < 75) begin
                hi = $urandom_range(1, 40);
            end else if (r < 97) begin
                hi = $urandom_range(41, 120);
            end else begin
                hi = $urandom_range(121, 400);
            end
            lo = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 10) : 1;
            send_pulse(hi, lo);
            sent += hi + lo;
        end
    endtask

    initial begin : stimulus
        logic [15:0] limits [5];
        int          sent;
        int          base_readings;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_echo_level = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        sender_gaps_on = 1'b1;
        hold_requests = 0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed, reset limit: lows from reset give nothing, then the shortest pulses.
        send_echo(1'b0);
        send_echo(1'b0);
        send_pulse(1, 1);
        send_pulse(6, 3);
        send_pulse(2, 1);
        send_pulse(12, 1);
        drain_readings();

        // Limit equal to the distance shows dashes; one below does not.
        write_limit(16'd1);
        send_pulse(5, 1);
        send_pulse(6, 1);
        drain_readings();

        // Zero limit: even a zero distance is out of range.
        write_limit(16'd0);
        send_pulse(1, 1);
        drain_readings();

        // Longer pulse, no gaps: a distance past one hundred lights the hundreds digit.
        sender_gaps_on = 1'b0;
        write_limit(16'hffff);
        send_pulse(600, 1);
        drain_readings();

        // Limit of twenty at its boundary: 116 ticks give exactly twenty, 115 give nineteen.
        write_limit(16'd20);
        send_pulse(116, 1);
        send_pulse(115, 1);
        drain_readings();

        // Fill the pipeline: the sink holds off while short pulses keep coming.
        hold_requests++;
        while (!holding) @(negedge aclk);
        repeat (60) send_pulse(1, 1);
        drain_readings();

        // Random phases over several limits, extremes among them.
        limits[0] = 16'($urandom_range(0, 60));
        limits[1] = 16'hffff;
        limits[2] = 16'($urandom_range(61, 130));
        limits[3] = 16'd0;
        limits[4] = 16'($urandom_range(0, 200));
        base_readings = readings_seen;
        for (int p = 0; p < 5; p++) begin
            write_limit(limits[p]);
            sender_gaps_on = (p != 2);
            sent = 0;
            while (sent < PHASE_WORDS
                   || (p == 4 && readings_seen - base_readings < MIN_RANDOM_READINGS)) begin
                send_random_burst(sent);
            end
            drain_readings();
        end

        if (mismatch_count == 0 && readings_pending == 0) begin
            $display("ultrasonic_echo_range_meter_unit_tb OK");
        end else begin
            $display("ultrasonic_echo_range_meter_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
